// File: hdl/skt_pkg.sv
// Package with the shared constants, codes and interface types of the sorted key table.
`timescale 1ns / 1ps

package skt_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int PAY_W   = 32;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 3;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;
    localparam int CAP_W   = 5;
    localparam int LIM_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 3'd0,
        CMD_DELETE  = 3'd1,
        CMD_LOOKUP  = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_RESTART = 3'd4,
        CMD_NEXT    = 3'd5
    } cmd_code_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 3'd0,
        ST_DUP  = 3'd1,
        ST_FULL = 3'd2,
        ST_MISS = 3'd3,
        ST_END  = 3'd4
    } stat_code_t;

    typedef enum logic [2:0] {
        RK_PLAIN,
        RK_DUP,
        RK_FULL,
        RK_INS,
        RK_FOUND,
        RK_MISS,
        RK_END,
        RK_ITER
    } res_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRD,
        S_SCMP,
        S_SHIFT,
        S_FIN,
        S_IWAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic      load;
        logic      srch_init;
        logic      srch_rd;
        logic      srch_cmp;
        logic      shift_init_up;
        logic      shift_init_dn;
        logic      shift_rd;
        logic      iter_rd;
        logic      iter_inc;
        logic      iter_clr;
        logic      cnt_clr;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      ins_wr;
        logic      set_res;
        res_kind_t res_kind;
        logic      out_load;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             srch_open;
        logic             key_eq;
        logic             full;
        logic             shift_more;
        logic             iter_more;
    } sts_t;

endpackage

// File: hdl/skt_datapath.sv
// Datapath of the sorted key table: entry memory, search pointers, counters and result registers.
`timescale 1ns / 1ps

module skt_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [skt_pkg::CAP_W-1:0]   cfg_wdata,
    input  logic [skt_pkg::CMD_W-1:0]   cmd,
    input  logic [skt_pkg::KEY_W-1:0]   key,
    input  logic [skt_pkg::PAY_W-1:0]   payload,
    input  skt_pkg::ctl_t               ctl,
    output skt_pkg::sts_t               sts,
    output logic [skt_pkg::STAT_W-1:0]  status,
    output logic [skt_pkg::POS_W-1:0]   position,
    output logic [skt_pkg::KEY_W-1:0]   key_out,
    output logic [skt_pkg::PAY_W-1:0]   payload_out,
    output logic [skt_pkg::COUNT_W-1:0] count
);

    logic [skt_pkg::KEY_W-1:0]  key_mem [skt_pkg::DEPTH];
    logic [skt_pkg::PAY_W-1:0]  pay_mem [skt_pkg::DEPTH];

    logic [skt_pkg::CAP_W-1:0]  cap_reg;
    logic [skt_pkg::CNT_W-1:0]  count_reg;
    logic [skt_pkg::CNT_W-1:0]  iter_reg;
    logic                       wr_pend_reg;

    logic [skt_pkg::CMD_W-1:0]  cmd_reg;
    logic [skt_pkg::KEY_W-1:0]  key_reg;
    logic [skt_pkg::PAY_W-1:0]  pay_reg;
    logic [skt_pkg::CNT_W-1:0]  lo_reg;
    logic [skt_pkg::CNT_W-1:0]  hi_reg;
    logic [skt_pkg::ADDR_W-1:0] mid_reg;
    logic [skt_pkg::CNT_W-1:0]  sp_reg;
    logic                       up_reg;
    logic [skt_pkg::ADDR_W-1:0] wr_addr_reg;
    logic [skt_pkg::KEY_W-1:0]  rd_key_reg;
    logic [skt_pkg::PAY_W-1:0]  rd_pay_reg;

    logic [skt_pkg::STAT_W-1:0]  res_status_reg;
    logic [skt_pkg::POS_W-1:0]   res_pos_reg;
    logic [skt_pkg::KEY_W-1:0]   res_key_reg;
    logic [skt_pkg::PAY_W-1:0]   res_pay_reg;
    logic [skt_pkg::STAT_W-1:0]  res_status_next;
    logic [skt_pkg::POS_W-1:0]   res_pos_next;
    logic [skt_pkg::KEY_W-1:0]   res_key_next;
    logic [skt_pkg::PAY_W-1:0]   res_pay_next;
    logic [skt_pkg::STAT_W-1:0]  out_status_reg;
    logic [skt_pkg::POS_W-1:0]   out_pos_reg;
    logic [skt_pkg::KEY_W-1:0]   out_key_reg;
    logic [skt_pkg::PAY_W-1:0]   out_pay_reg;
    logic [skt_pkg::COUNT_W-1:0] out_count_reg;

    logic [skt_pkg::CNT_W:0]    mid_sum;
    logic [skt_pkg::CNT_W-1:0]  mid_next;
    logic [skt_pkg::CNT_W-1:0]  sp_dec;
    logic [skt_pkg::LIM_W-1:0]  lim_cap;
    logic [skt_pkg::LIM_W-1:0]  lim_depth;
    logic [skt_pkg::LIM_W-1:0]  limit;
    logic                       rd_en;
    logic [skt_pkg::ADDR_W-1:0] rd_addr;

    // The midpoint is (lo + hi - 1) / 2 with hi kept as one past the last candidate.
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} - (skt_pkg::CNT_W + 1)'(1);
    assign mid_next = mid_sum[skt_pkg::CNT_W:1];
    assign sp_dec   = sp_reg - skt_pkg::CNT_W'(1);

    assign lim_cap   = skt_pkg::LIM_W'(cap_reg);
    assign lim_depth = skt_pkg::LIM_W'(skt_pkg::DEPTH);
    assign limit     = (lim_cap < lim_depth) ? lim_cap : lim_depth;

    assign sts.cmd        = cmd_reg;
    assign sts.srch_open  = lo_reg < hi_reg;
    assign sts.key_eq     = rd_key_reg == key_reg;
    assign sts.full       = skt_pkg::LIM_W'(count_reg) >= limit;
    assign sts.shift_more = up_reg ? (sp_reg > lo_reg) : (sp_reg < count_reg);
    assign sts.iter_more  = iter_reg < count_reg;

    always_comb
    begin
        rd_en   = ctl.srch_rd | ctl.shift_rd | ctl.iter_rd;
        rd_addr = iter_reg[skt_pkg::ADDR_W-1:0];
        if (ctl.srch_rd)
        begin
            rd_addr = mid_next[skt_pkg::ADDR_W-1:0];
        end
        else if (ctl.shift_rd)
        begin
            rd_addr = up_reg ? sp_dec[skt_pkg::ADDR_W-1:0] : sp_reg[skt_pkg::ADDR_W-1:0];
        end
    end

    always_comb
    begin
        res_status_next = skt_pkg::ST_OK;
        res_pos_next    = '0;
        res_key_next    = '0;
        res_pay_next    = '0;
        case (ctl.res_kind)
            skt_pkg::RK_PLAIN:
            begin
                res_status_next = skt_pkg::ST_OK;
            end
            skt_pkg::RK_DUP:
            begin
                res_status_next = skt_pkg::ST_DUP;
                res_pos_next    = skt_pkg::POS_W'(mid_reg);
                res_key_next    = rd_key_reg;
                res_pay_next    = rd_pay_reg;
            end
            skt_pkg::RK_FULL:
            begin
                res_status_next = skt_pkg::ST_FULL;
            end
            skt_pkg::RK_INS:
            begin
                res_pos_next = skt_pkg::POS_W'(lo_reg);
            end
            skt_pkg::RK_FOUND:
            begin
                res_pos_next = skt_pkg::POS_W'(mid_reg);
                res_key_next = rd_key_reg;
                res_pay_next = rd_pay_reg;
            end
            skt_pkg::RK_MISS:
            begin
                res_status_next = skt_pkg::ST_MISS;
            end
            skt_pkg::RK_END:
            begin
                res_status_next = skt_pkg::ST_END;
            end
            skt_pkg::RK_ITER:
            begin
                res_pos_next = skt_pkg::POS_W'(iter_reg);
                res_key_next = rd_key_reg;
                res_pay_next = rd_pay_reg;
            end
            default:
            begin
                res_status_next = skt_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_pay_reg <= pay_mem[rd_addr];
        end
        if (wr_pend_reg)
        begin
            key_mem[wr_addr_reg] <= rd_key_reg;
            pay_mem[wr_addr_reg] <= rd_pay_reg;
        end
        else if (ctl.ins_wr)
        begin
            key_mem[lo_reg[skt_pkg::ADDR_W-1:0]] <= key_reg;
            pay_mem[lo_reg[skt_pkg::ADDR_W-1:0]] <= pay_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= skt_pkg::CAP_RESET;
            count_reg   <= '0;
            iter_reg    <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (ctl.cnt_clr)
            begin
                count_reg <= '0;
            end
            else if (ctl.cnt_inc)
            begin
                count_reg <= count_reg + skt_pkg::CNT_W'(1);
            end
            else if (ctl.cnt_dec)
            begin
                count_reg <= count_reg - skt_pkg::CNT_W'(1);
            end
            if (ctl.iter_clr)
            begin
                iter_reg <= '0;
            end
            else if (ctl.iter_inc)
            begin
                iter_reg <= iter_reg + skt_pkg::CNT_W'(1);
            end
            wr_pend_reg <= ctl.shift_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            key_reg <= key;
            pay_reg <= payload;
        end
        if (ctl.srch_init)
        begin
            lo_reg <= '0;
            hi_reg <= count_reg;
        end
        else if (ctl.srch_cmp)
        begin
            if (rd_key_reg < key_reg)
            begin
                lo_reg <= skt_pkg::CNT_W'(mid_reg) + skt_pkg::CNT_W'(1);
            end
            else
            begin
                hi_reg <= skt_pkg::CNT_W'(mid_reg);
            end
        end
        if (ctl.srch_rd)
        begin
            mid_reg <= mid_next[skt_pkg::ADDR_W-1:0];
        end
        if (ctl.shift_init_up)
        begin
            sp_reg <= count_reg;
            up_reg <= 1'b1;
        end
        else if (ctl.shift_init_dn)
        begin
            sp_reg <= skt_pkg::CNT_W'(mid_reg) + skt_pkg::CNT_W'(1);
            up_reg <= 1'b0;
        end
        else if (ctl.shift_rd)
        begin
            if (up_reg)
            begin
                wr_addr_reg <= sp_reg[skt_pkg::ADDR_W-1:0];
                sp_reg      <= sp_dec;
            end
            else
            begin
                wr_addr_reg <= sp_dec[skt_pkg::ADDR_W-1:0];
                sp_reg      <= sp_reg + skt_pkg::CNT_W'(1);
            end
        end
        if (ctl.set_res)
        begin
            res_status_reg <= res_status_next;
            res_pos_reg    <= res_pos_next;
            res_key_reg    <= res_key_next;
            res_pay_reg    <= res_pay_next;
        end
        if (ctl.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_pos_reg    <= res_pos_reg;
            out_key_reg    <= res_key_reg;
            out_pay_reg    <= res_pay_reg;
            out_count_reg  <= skt_pkg::COUNT_W'(count_reg);
        end
    end

    assign status      = out_status_reg;
    assign position    = out_pos_reg;
    assign key_out     = out_key_reg;
    assign payload_out = out_pay_reg;
    assign count       = out_count_reg;

endmodule

// File: hdl/skt_ctrl.sv
// Controller state machine of the sorted key table that sequences search, shift and result transfer.
`timescale 1ns / 1ps

module skt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  skt_pkg::sts_t sts,
    output skt_pkg::ctl_t ctl
);

    skt_pkg::state_t state_reg;
    skt_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = skt_pkg::S_DISPATCH;
                end
            end
            skt_pkg::S_DISPATCH:
            begin
                case (sts.cmd)
                    skt_pkg::CMD_INSERT, skt_pkg::CMD_DELETE, skt_pkg::CMD_LOOKUP:
                    begin
                        state_next = skt_pkg::S_SRD;
                    end
                    skt_pkg::CMD_NEXT:
                    begin
                        state_next = sts.iter_more ? skt_pkg::S_IWAIT : skt_pkg::S_DONE;
                    end
                    default:
                    begin
                        state_next = skt_pkg::S_DONE;
                    end
                endcase
            end
            skt_pkg::S_SRD:
            begin
                if (sts.srch_open)
                begin
                    state_next = skt_pkg::S_SCMP;
                end
                else if (sts.cmd == skt_pkg::CMD_INSERT && !sts.full)
                begin
                    state_next = skt_pkg::S_SHIFT;
                end
                else
                begin
                    state_next = skt_pkg::S_DONE;
                end
            end
            skt_pkg::S_SCMP:
            begin
                if (!sts.key_eq)
                begin
                    state_next = skt_pkg::S_SRD;
                end
                else if (sts.cmd == skt_pkg::CMD_DELETE)
                begin
                    state_next = skt_pkg::S_SHIFT;
                end
                else
                begin
                    state_next = skt_pkg::S_DONE;
                end
            end
            skt_pkg::S_SHIFT:
            begin
                if (!sts.shift_more)
                begin
                    state_next = skt_pkg::S_FIN;
                end
            end
            skt_pkg::S_FIN:
            begin
                state_next = skt_pkg::S_DONE;
            end
            skt_pkg::S_IWAIT:
            begin
                state_next = skt_pkg::S_DONE;
            end
            skt_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = skt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        in_ready = 1'b0;
        case (state_reg)
            skt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            skt_pkg::S_DISPATCH:
            begin
                case (sts.cmd)
                    skt_pkg::CMD_INSERT, skt_pkg::CMD_DELETE, skt_pkg::CMD_LOOKUP:
                    begin
                        ctl.srch_init = 1'b1;
                    end
                    skt_pkg::CMD_CLEAR:
                    begin
                        ctl.cnt_clr  = 1'b1;
                        ctl.iter_clr = 1'b1;
                        ctl.set_res  = 1'b1;
                        ctl.res_kind = skt_pkg::RK_PLAIN;
                    end
                    skt_pkg::CMD_RESTART:
                    begin
                        ctl.iter_clr = 1'b1;
                        ctl.set_res  = 1'b1;
                        ctl.res_kind = skt_pkg::RK_PLAIN;
                    end
                    skt_pkg::CMD_NEXT:
                    begin
                        if (sts.iter_more)
                        begin
                            ctl.iter_rd = 1'b1;
                        end
                        else
                        begin
                            ctl.set_res  = 1'b1;
                            ctl.res_kind = skt_pkg::RK_END;
                        end
                    end
                    default:
                    begin
                        ctl.set_res  = 1'b1;
                        ctl.res_kind = skt_pkg::RK_PLAIN;
                    end
                endcase
            end
            skt_pkg::S_SRD:
            begin
                if (sts.srch_open)
                begin
                    ctl.srch_rd = 1'b1;
                end
                else if (sts.cmd == skt_pkg::CMD_INSERT)
                begin
                    ctl.set_res = 1'b1;
                    if (sts.full)
                    begin
                        ctl.res_kind = skt_pkg::RK_FULL;
                    end
                    else
                    begin
                        ctl.res_kind      = skt_pkg::RK_INS;
                        ctl.shift_init_up = 1'b1;
                    end
                end
                else
                begin
                    ctl.set_res  = 1'b1;
                    ctl.res_kind = skt_pkg::RK_MISS;
                end
            end
            skt_pkg::S_SCMP:
            begin
                if (!sts.key_eq)
                begin
                    ctl.srch_cmp = 1'b1;
                end
                else
                begin
                    ctl.set_res = 1'b1;
                    if (sts.cmd == skt_pkg::CMD_INSERT)
                    begin
                        ctl.res_kind = skt_pkg::RK_DUP;
                    end
                    else
                    begin
                        ctl.res_kind      = skt_pkg::RK_FOUND;
                        ctl.shift_init_dn = sts.cmd == skt_pkg::CMD_DELETE;
                    end
                end
            end
            skt_pkg::S_SHIFT:
            begin
                ctl.shift_rd = sts.shift_more;
            end
            skt_pkg::S_FIN:
            begin
                if (sts.cmd == skt_pkg::CMD_INSERT)
                begin
                    ctl.ins_wr  = 1'b1;
                    ctl.cnt_inc = 1'b1;
                end
                else
                begin
                    ctl.cnt_dec = 1'b1;
                end
            end
            skt_pkg::S_IWAIT:
            begin
                ctl.set_res  = 1'b1;
                ctl.res_kind = skt_pkg::RK_ITER;
                ctl.iter_inc = 1'b1;
            end
            skt_pkg::S_DONE:
            begin
                ctl.out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skt_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // A new result never overwrites one that has not been transferred.
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register loaded while occupied");

    // An accepted command always starts in the dispatch state.
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == skt_pkg::S_DISPATCH))
        else $error("accepted command not dispatched");

    // The shift finishes only once no entries remain to move.
    a_shift_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == skt_pkg::S_SHIFT && !sts.shift_more) |=> (state_reg == skt_pkg::S_FIN))
        else $error("shift did not finish cleanly");

    // Search pointers are written only in their own states, besides their initialisation in the dispatch state.
    a_search_cmds: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.srch_rd || ctl.srch_cmp) |-> (state_reg == skt_pkg::S_SRD || state_reg == skt_pkg::S_SCMP))
        else $error("search step outside search states");
`endif

endmodule

// File: hdl/sorted_key_table.sv
// Top level of the sorted key table: controller and datapath joined by command and status structs.
// Throughput: one command at a time; the next is accepted once the result is in the output register.
// The binary search reads the entry memory through its read port once per step, and the shift moves
// one entry per cycle, read through that port and written back through the separate write port.
// Reset clears count, iteration pointer and sets capacity to 10.
`timescale 1ns / 1ps

module sorted_key_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [skt_pkg::CAP_W-1:0]   cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [skt_pkg::CMD_W-1:0]   cmd,
    input  logic [skt_pkg::KEY_W-1:0]   key,
    input  logic [skt_pkg::PAY_W-1:0]   payload,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [skt_pkg::STAT_W-1:0]  status,
    output logic [skt_pkg::POS_W-1:0]   position,
    output logic [skt_pkg::KEY_W-1:0]   key_out,
    output logic [skt_pkg::PAY_W-1:0]   payload_out,
    output logic [skt_pkg::COUNT_W-1:0] count
);

    skt_pkg::ctl_t ctl;
    skt_pkg::sts_t sts;

    skt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    skt_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .key         (key),
        .payload     (payload),
        .ctl         (ctl),
        .sts         (sts),
        .status      (status),
        .position    (position),
        .key_out     (key_out),
        .payload_out (payload_out),
        .count       (count)
    );

endmodule
